FILE: sv/pfp_pkg.sv
// Shared widths and pipeline depths for the plane-from-three-points unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package pfp_pkg;

	localparam int unsigned COORD_W  = 24;   // vertex coordinate, Q.8
	localparam int unsigned EDGE_W   = 25;   // edge component, Q.8
	localparam int unsigned PROD_W   = 50;   // edge product, Q.16
	localparam int unsigned CROSS_W  = 51;   // cross component, Q.16
	localparam int unsigned RED_W    = 30;   // reduced magnitude
	localparam int unsigned SQ_W     = 62;   // sum of three squares
	localparam int unsigned LEN_W    = 31;   // floor square root
	localparam int unsigned QUO_W    = 18;   // doubled normal magnitude
	localparam int unsigned NORM_W   = 18;   // Q1.16 normal component
	localparam int unsigned DIST_W   = 25;   // plane distance, Q.8
	localparam int unsigned MINL_W   = 16;   // threshold register
	localparam int unsigned SHIFT_W  = 5;    // normalizing shift, 0..21

	localparam int unsigned SQRT_STAGES = 32;
	localparam int unsigned DIV_STAGES  = QUO_W;
	localparam int unsigned FRONT_STAGES = 8;
	localparam int unsigned BACK_STAGES  = 3;
	localparam int unsigned LATENCY =
		FRONT_STAGES + SQRT_STAGES + DIV_STAGES + BACK_STAGES;

	// Values that ride alongside the square root and the dividers.
	typedef struct packed {
		logic                       k_zero;
		logic [2:0][RED_W-1:0]      red;
	} pfp_red_t;

	typedef struct packed {
		logic [2:0]                 neg;
		logic [2:0][COORD_W-1:0]    p0;
	} pfp_side_t;

endpackage
`default_nettype wire

FILE: sv/pfp_delay.sv
// Enable-gated shift line that keeps side data aligned with the pipeline.
// Depends on pfp_pkg.
`default_nettype none
module pfp_delay
	import pfp_pkg::*;
#(
	parameter int unsigned W     = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= din;
			for (int i = 1; i < int'(DEPTH); i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];

endmodule
`default_nettype wire

FILE: sv/pfp_sqrt.sv
// Pipelined integer square root, one result bit resolved per stage.
// Depends on pfp_pkg.
`default_nettype none
module pfp_sqrt
	import pfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [SQ_W-1:0]   radicand,
	output logic      [LEN_W-1:0]  root
);

	logic [SQ_W-1:0] x_s   [SQRT_STAGES+1];
	logic [SQ_W:0]   res_s [SQRT_STAGES+1];

	assign x_s[0]   = radicand;
	assign res_s[0] = '0;

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		localparam logic [SQ_W:0] BIT_C = (SQ_W+1)'(1) << (SQ_W - 2*j);
		logic [SQ_W+1:0] trial;
		logic            take;

		assign trial = {1'b0, res_s[j]} + {1'b0, BIT_C};
		assign take  = {2'b00, x_s[j]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					x_s[j+1]   <= SQ_W'({2'b00, x_s[j]} - trial);
					res_s[j+1] <= (res_s[j] >> 1) + BIT_C;
				end else begin
					x_s[j+1]   <= x_s[j];
					res_s[j+1] <= res_s[j] >> 1;
				end
			end
		end
	end

	assign root = res_s[SQRT_STAGES][LEN_W-1:0];

endmodule
`default_nettype wire

FILE: sv/pfp_div.sv
// Pipelined restoring divider: (num << 17) / den, one quotient bit per stage.
// The numerator never exceeds the divisor, so the quotient fits in 18 bits.
// Depends on pfp_pkg.
`default_nettype none
module pfp_div
	import pfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [RED_W-1:0]  num,
	input  wire logic [LEN_W-1:0]  den,
	output logic      [QUO_W-1:0]  quo
);

	logic [LEN_W-1:0] rem_s [DIV_STAGES+1];
	logic [LEN_W-1:0] den_s [DIV_STAGES+1];
	logic [QUO_W-1:0] quo_s [DIV_STAGES+1];

	assign rem_s[0] = '0;
	assign den_s[0] = den;
	assign quo_s[0] = '0;

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [LEN_W:0] shifted;
		logic           fits;

		// The first step brings in the whole numerator at once.
		if (i == 0) begin : g_first
			assign shifted = (LEN_W+1)'(num);
		end else begin : g_rest
			assign shifted = {rem_s[i], 1'b0};
		end

		assign fits = shifted >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= fits ? LEN_W'(shifted - {1'b0, den_s[i]})
				                   : LEN_W'(shifted);
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= {quo_s[i][QUO_W-2:0], fits};
			end
		end
	end

	assign quo = quo_s[DIV_STAGES];

endmodule
`default_nettype wire

FILE: sv/plane_from_three_points_unit.sv
// Plane from three points: unit normal in Q1.16 and plane distance in Q.8.
// Input channel in_valid/in_ready carries the nine vertex coordinates; the
// output channel out_valid/out_ready carries normal, distance and the
// degenerate flag. One beat in gives exactly one beat out, in order.
// The pipeline has 61 register stages; out_valid rises together with the
// result registers of the last stage.
// The stages are 8 front stages
// (edges, products, cross, magnitude, shift search, shift, squares, sum),
// 32 square-root stages, 18 divider stages and 3 back stages (rounding,
// distance products, distance sum with saturation).
// Throughput is one beat per cycle. The whole pipeline advances together;
// when out_valid is high and out_ready low, every stage holds and in_ready
// drops, so nothing is lost or repeated.
// The user writes the min_length register with cfg_wen/cfg_wdata only while the
// unit is empty; the block does not enforce this. Reset clears all valid bits and
// sets min_length to 7. Depends on pfp_pkg, pfp_delay, pfp_sqrt and pfp_div.
`default_nettype none
module plane_from_three_points_unit
	import pfp_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wen,
	input  wire logic        [MINL_W-1:0]    cfg_wdata,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [COORD_W-1:0]   v0_x,
	input  wire logic signed [COORD_W-1:0]   v0_y,
	input  wire logic signed [COORD_W-1:0]   v0_z,
	input  wire logic signed [COORD_W-1:0]   v1_x,
	input  wire logic signed [COORD_W-1:0]   v1_y,
	input  wire logic signed [COORD_W-1:0]   v1_z,
	input  wire logic signed [COORD_W-1:0]   v2_x,
	input  wire logic signed [COORD_W-1:0]   v2_y,
	input  wire logic signed [COORD_W-1:0]   v2_z,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed      [NORM_W-1:0]    normal_x,
	output logic signed      [NORM_W-1:0]    normal_y,
	output logic signed      [NORM_W-1:0]    normal_z,
	output logic signed      [DIST_W-1:0]    plane_dist,
	output logic                             degenerate
);

	logic [MINL_W-1:0]  min_length_q;
	logic [LATENCY-1:0] vld_q;
	logic               en;

	assign out_valid = vld_q[LATENCY-1];
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MINL_W'(7);
			vld_q        <= '0;
		end else begin
			if (cfg_wen) begin
				min_length_q <= cfg_wdata;
			end
			if (en) begin
				vld_q <= {vld_q[LATENCY-2:0], in_valid};
			end
		end
	end

	// Front stages.
	logic signed [EDGE_W-1:0]  ux_s1, uy_s1, uz_s1, wx_s1, wy_s1, wz_s1;
	logic [2:0][COORD_W-1:0]   p0_s1, p0_s2, p0_s3, p0_s4, p0_s5, p0_s6;
	logic signed [PROD_W-1:0]  a_s2 [3];
	logic signed [PROD_W-1:0]  b_s2 [3];
	logic signed [CROSS_W-1:0] c_s3 [3];
	logic [CROSS_W-1:0]        m_s4 [3];
	logic [2:0]                neg_s4, neg_s5, neg_s6;
	logic [CROSS_W-1:0]        m_s5 [3];
	logic [SHIFT_W-1:0]        k_s5;
	logic [2:0][RED_W-1:0]     r_s6;
	logic                      kz_s6;
	logic [2*RED_W-1:0]        sq_s7 [3];
	logic [SQ_W-1:0]           sum_s8;
	logic [CROSS_W-1:0]        or_mag;
	logic [SHIFT_W-1:0]        k_next;

	always_comb begin
		or_mag = m_s4[0] | m_s4[1] | m_s4[2];
		k_next = '0;
		for (int b = RED_W; b < int'(CROSS_W); b++) begin
			if (or_mag[b]) begin
				k_next = SHIFT_W'(b - int'(RED_W) + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= EDGE_W'(v1_x) - EDGE_W'(v0_x);
			uy_s1 <= EDGE_W'(v1_y) - EDGE_W'(v0_y);
			uz_s1 <= EDGE_W'(v1_z) - EDGE_W'(v0_z);
			wx_s1 <= EDGE_W'(v2_x) - EDGE_W'(v0_x);
			wy_s1 <= EDGE_W'(v2_y) - EDGE_W'(v0_y);
			wz_s1 <= EDGE_W'(v2_z) - EDGE_W'(v0_z);
			p0_s1 <= {v0_z, v0_y, v0_x};

			a_s2[0] <= uy_s1 * wz_s1;
			b_s2[0] <= uz_s1 * wy_s1;
			a_s2[1] <= uz_s1 * wx_s1;
			b_s2[1] <= ux_s1 * wz_s1;
			a_s2[2] <= ux_s1 * wy_s1;
			b_s2[2] <= uy_s1 * wx_s1;
			p0_s2   <= p0_s1;

			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= CROSS_W'(a_s2[i]) - CROSS_W'(b_s2[i]);
				m_s4[i] <= c_s3[i][CROSS_W-1] ? CROSS_W'(-c_s3[i]) : CROSS_W'(c_s3[i]);
				neg_s4[i] <= c_s3[i][CROSS_W-1];
				m_s5[i] <= m_s4[i];
				r_s6[i] <= RED_W'(m_s5[i] >> k_s5);
				sq_s7[i] <= r_s6[i] * r_s6[i];
			end
			p0_s3  <= p0_s2;
			p0_s4  <= p0_s3;
			p0_s5  <= p0_s4;
			p0_s6  <= p0_s5;
			neg_s5 <= neg_s4;
			neg_s6 <= neg_s5;
			k_s5   <= k_next;
			kz_s6  <= (k_s5 == '0);
			sum_s8 <= SQ_W'(sq_s7[0]) + SQ_W'(sq_s7[1]) + SQ_W'(sq_s7[2]);
		end
	end

	// Square root, with reduced magnitudes riding alongside.
	logic [LEN_W-1:0] len;
	pfp_red_t         red_in, red_out;
	pfp_side_t        side_in, side_out;

	assign red_in  = '{k_zero: kz_s6, red: r_s6};
	assign side_in = '{neg: neg_s6, p0: p0_s6};

	pfp_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s8),
		.root     (len)
	);

	pfp_delay #(.W($bits(pfp_red_t)), .DEPTH(2 + SQRT_STAGES)) u_red_dly (
		.clk  (clk),
		.en   (en),
		.din  (red_in),
		.dout (red_out)
	);

	pfp_delay #(.W($bits(pfp_side_t)), .DEPTH(2 + SQRT_STAGES + DIV_STAGES)) u_side_dly (
		.clk  (clk),
		.en   (en),
		.din  (side_in),
		.dout (side_out)
	);

	// A zero length is degenerate even when the threshold is zero.
	logic deg_in, deg_out;
	assign deg_in = (len == '0) ||
	                (red_out.k_zero && (len < LEN_W'(min_length_q)));

	pfp_delay #(.W(1), .DEPTH(DIV_STAGES)) u_deg_dly (
		.clk  (clk),
		.en   (en),
		.din  (deg_in),
		.dout (deg_out)
	);

	logic [QUO_W-1:0] quo [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		pfp_div u_div (
			.clk (clk),
			.en  (en),
			.num (red_out.red[i]),
			.den (len),
			.quo (quo[i])
		);
	end

	// Back stages: round, distance products, distance sum.
	localparam int unsigned DPROD_W = NORM_W + COORD_W;
	localparam int unsigned DSUM_W  = DPROD_W + 2;
	localparam int unsigned DSH_W   = DSUM_W - 16;

	logic signed [NORM_W-1:0]  n_s1b [3];
	logic signed [NORM_W-1:0]  n_s2b [3];
	logic signed [DPROD_W-1:0] dp_s2b [3];
	logic                      deg_s1b, deg_s2b;
	logic [QUO_W:0]            q_inc [3];
	logic [QUO_W-1:0]          q_half [3];
	logic signed [DSUM_W-1:0]  dsum;
	logic signed [DSH_W-1:0]   dsh;
	logic signed [DIST_W-1:0]  dist_sat;
	// The vertex is needed one stage after the rounding stage.
	logic [2:0][COORD_W-1:0]   side_out_p0_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_inc[i]  = {1'b0, quo[i]} + (QUO_W+1)'(1);
			q_half[i] = q_inc[i][QUO_W:1];
		end
		dsum = DSUM_W'(dp_s2b[0]) + DSUM_W'(dp_s2b[1]) + DSUM_W'(dp_s2b[2])
		     + DSUM_W'(32768);
		dsh  = DSH_W'(dsum >>> 16);
		if (dsh > DSH_W'(16777215)) begin
			dist_sat = DIST_W'(16777215);
		end else if (dsh < -DSH_W'(16777216)) begin
			dist_sat = -DIST_W'(16777216);
		end else begin
			dist_sat = DIST_W'(dsh);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				n_s1b[i] <= side_out.neg[i] ? -NORM_W'(q_half[i]) : NORM_W'(q_half[i]);
				n_s2b[i] <= n_s1b[i];
				dp_s2b[i] <= DPROD_W'(n_s1b[i]) * DPROD_W'($signed(side_out_p0_q[i]));
			end
			deg_s1b <= deg_out;
			deg_s2b <= deg_s1b;

			normal_x   <= deg_s2b ? '0 : n_s2b[0];
			normal_y   <= deg_s2b ? '0 : n_s2b[1];
			normal_z   <= deg_s2b ? '0 : n_s2b[2];
			plane_dist <= deg_s2b ? '0 : dist_sat;
			degenerate <= deg_s2b;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out_p0_q <= side_out.p0;
		end
	end

endmodule
`default_nettype wire
